// ===== hdl/jbt_pkg.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants of the JSON byte tokenizer.
//------------------------------------------------------------------------------
package jbt_pkg;

   localparam int OFFSET_WIDTH = 32;

   typedef logic [3:0]              kind_type;
   typedef logic [OFFSET_WIDTH-1:0] pos_type;

   localparam kind_type K_ERROR = 4'd0;
   localparam kind_type K_END   = 4'd1;
   localparam kind_type K_LBRACE = 4'd2;
   localparam kind_type K_RBRACE = 4'd3;
   localparam kind_type K_LBRACK = 4'd4;
   localparam kind_type K_RBRACK = 4'd5;
   localparam kind_type K_COLON = 4'd6;
   localparam kind_type K_COMMA = 4'd7;
   localparam kind_type K_STRING = 4'd8;
   localparam kind_type K_TRUE  = 4'd9;
   localparam kind_type K_FALSE = 4'd10;
   localparam kind_type K_NULL  = 4'd11;
   localparam kind_type K_INT   = 4'd12;
   localparam kind_type K_FRAC  = 4'd13;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      kind_type     kind;
      logic [31:0]  offset;
      logic [31:0]  length;
      logic [63:0]  value;
      logic         last;
   } token_type;

   // queue word between the front and back parts
   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } byte_word_type;

   localparam int QDEPTH = 4;
   localparam int QAW = $clog2(QDEPTH);

   localparam logic [62:0] MAG_MAX = {63{1'b1}};
   localparam logic [62:0] MAG_LIM = 63'd922337203685477580;

endpackage
`default_nettype wire

// ===== hdl/json_byte_tokenizer.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// json_byte_tokenizer
// JSON lexer: bytes in, tokens out, both sides as queues.
//------------------------------------------------------------------------------
// Push one word per cycle on req_ (command, text_byte) while full is low.
// A word of command 1 flushes any pending token and yields an end token;
// offsets then restart at zero. Tokens leave on rsp_ while rsp_empty is low
// and are taken with rsp_pop. One byte yields zero, one or two tokens;
// run_last marks the last one of a byte.
// A token passes through the input queue, the lexer register and the output
// stage before it can be popped. Throughput is one byte per cycle while the
// receiver keeps popping, set by the lexer step; a byte giving two tokens
// occupies the output stage for two pops. A stalled receiver backs up the
// output stage, then the four-word input queue, then raises req_full.
// Reset empties both queues and returns the lexer to idle at offset zero.
//------------------------------------------------------------------------------
module json_byte_tokenizer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire         req_command,
   input  wire  [7:0]  req_text_byte,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic [31:0] rsp_token_offset,
   output logic [31:0] rsp_token_length,
   output logic signed [63:0] rsp_integer_value,
   output logic        rsp_run_last
);
   import jbt_pkg::*;

   byte_word_type qin, qout;
   logic          q_empty, take, lx_valid, free;
   logic [1:0]    lx_count;
   token_type     lx0, lx1, tok;

   assign qin.cmd  = req_command;
   assign qin.data = req_text_byte;

   jbt_queue u_queue (
      .clock(clock), .reset(reset), .push(req_push), .push_word(qin), .full(req_full),
      .pop(take), .pop_word(qout), .empty(q_empty)
   );

   jbt_lexer u_lexer (
      .clock(clock), .reset(reset), .in_word(qout), .in_valid(!q_empty), .in_take(take),
      .out_valid(lx_valid), .out_count(lx_count), .out_tok0(lx0), .out_tok1(lx1),
      .out_free(free)
   );

   jbt_emit u_emit (
      .clock(clock), .reset(reset), .in_valid(lx_valid), .in_count(lx_count),
      .in_tok0(lx0), .in_tok1(lx1), .in_free(free), .empty(rsp_empty), .pop(rsp_pop),
      .tok(tok)
   );

   assign rsp_token_kind    = tok.kind;
   assign rsp_token_offset  = tok.offset;
   assign rsp_token_length  = tok.length;
   assign rsp_integer_value = tok.value;
   assign rsp_run_last      = tok.last;

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind == K_END) |-> rsp_run_last)
      else $error("end token not last");
   a_int_only: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind != K_INT) |-> rsp_integer_value == 64'sd0)
      else $error("value on non-integer token");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!rsp_empty && !rsp_pop) && !$past(reset)) |-> !rsp_empty && $stable(tok))
      else $error("token changed while stalled");
endmodule
`default_nettype wire

// ===== hdl/jbt_queue.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// jbt_queue
// Short word queue between the byte front and the lexer back end.
//------------------------------------------------------------------------------
module jbt_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire jbt_pkg::byte_word_type push_word,
   output logic                   full,
   input  wire                    pop,
   output jbt_pkg::byte_word_type pop_word,
   output logic                   empty
);
   import jbt_pkg::*;

   byte_word_type   mem [QDEPTH];
   logic [QAW:0]    count_ff, count_in;
   logic [QAW-1:0]  rd_ff, wr_ff;
   logic            do_push, do_pop;

   assign full     = count_ff == QAW'(0) + (QAW+1)'(QDEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_word;
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
         wr_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/jbt_lexer.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// jbt_lexer
// Lexer back end: takes one queued word per cycle when not stalled, forms up to two tokens.
//------------------------------------------------------------------------------
module jbt_lexer (
   input  wire                    clock,
   input  wire                    reset,
   input  wire jbt_pkg::byte_word_type in_word,
   input  wire                    in_valid,
   output logic                   in_take,
   output logic                   out_valid,
   output logic [1:0]             out_count,
   output jbt_pkg::token_type     out_tok0,
   output jbt_pkg::token_type     out_tok1,
   input  wire                    out_free
);
   import jbt_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, M_STR, M_ESC, M_LIT, M_NEG, M_ZERO, M_INT,
      M_DOT, M_FRAC, M_EXP, M_EXPS, M_EXPD
   } mode_type;

   mode_type     mode_ff, mode_in;
   pos_type      pos_ff, pos_in, beg_ff, beg_in;
   logic [62:0]  mag_ff, mag_in;
   logic         ovf_ff, ovf_in, neg_ff, neg_in, frc_ff, frc_in;
   logic [2:0]   lidx_ff, lidx_in;
   logic [1:0]   lsel_ff, lsel_in;
   logic         valid_ff;
   logic [1:0]   cnt_ff, cnt_in;
   token_type    t0_ff, t1_ff, t0_in, t1_in;

   logic [7:0]   b;
   logic         dig, ech, restart;
   logic [3:0]   d;
   pos_type      p;

   assign in_take   = in_valid && (!valid_ff || out_free);
   assign out_valid = valid_ff;
   assign out_count = cnt_ff;
   assign out_tok0  = t0_ff;
   assign out_tok1  = t1_ff;

   function automatic logic [7:0] lit_char(input logic [1:0] s, input logic [2:0] i);
      logic [7:0] c;
      c = 8'h00;
      case (s)
         2'd0: case (i) 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00; endcase
         2'd1: case (i) 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
                  default: c = 8'h00; endcase
         2'd2: case (i) 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00; endcase
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] s);
      return (s == 2'd1) ? 3'd5 : 3'd4;
   endfunction

   always_comb begin
      token_type tk;
      logic [62:0] lim;
      logic [63:0] v;
      b   = in_word.data;
      p   = pos_ff;
      dig = b >= "0" && b <= "9";
      ech = b == "e" || b == "E";
      d   = b[3:0];
      mode_in = mode_ff; pos_in = pos_ff; beg_in = beg_ff; mag_in = mag_ff;
      ovf_in = ovf_ff; neg_in = neg_ff; frc_in = frc_ff;
      lidx_in = lidx_ff; lsel_in = lsel_ff;
      cnt_in = 2'd0;
      t0_in = '0; t1_in = '0;
      restart = 1'b0;
      tk = '0;
      lim = '0;
      v = '0;

      // finished-number value
      if (!frc_ff) begin
         if (ovf_ff) v = neg_ff ? 64'h8000_0000_0000_0000 : {1'b0, MAG_MAX};
         else        v = neg_ff ? (64'd0 - {1'b0, mag_ff}) : {1'b0, mag_ff};
      end

      if (in_word.cmd == CMD_END) begin
         case (mode_ff)
            M_ZERO, M_INT, M_FRAC, M_EXPD: begin
               t0_in = '{frc_ff ? K_FRAC : K_INT, 32'(beg_ff), 32'(p - beg_ff), v, 1'b0};
               cnt_in = 2'd1;
            end
            M_IDLE: ;
            default: begin
               t0_in = '{K_ERROR, 32'(beg_ff), 32'(p - beg_ff), 64'd0, 1'b0};
               cnt_in = 2'd1;
            end
         endcase
         tk = '{K_END, 32'(p), 32'd0, 64'd0, 1'b1};
         if (cnt_in == 2'd1) t1_in = tk; else t0_in = tk;
         cnt_in  = cnt_in + 2'd1;
         mode_in = M_IDLE;
         pos_in  = '0;
      end else begin
         pos_in = p + 1'b1;
         lim = MAG_LIM - 63'(d > 4'd7);
         case (mode_ff)
            M_IDLE: restart = 1'b1;
            M_STR: begin
               if (b == "\"") begin
                  t0_in = '{K_STRING, 32'(beg_ff), 32'(p - beg_ff), 64'd0, 1'b0};
                  cnt_in = 2'd1; mode_in = M_IDLE;
               end else if (b == "\\") mode_in = M_ESC;
            end
            M_ESC: mode_in = M_STR;
            M_LIT: begin
               if (lidx_ff < lit_len(lsel_ff) && lit_char(lsel_ff, lidx_ff) == b) begin
                  lidx_in = lidx_ff + 1'b1;
                  if (lidx_in >= lit_len(lsel_ff)) begin
                     t0_in = '{K_TRUE + 4'(lsel_ff), 32'(beg_ff),
                               32'(lit_len(lsel_ff)), 64'd0, 1'b0};
                     cnt_in = 2'd1; mode_in = M_IDLE;
                  end
               end else begin
                  t0_in = '{K_ERROR, 32'(beg_ff), 32'(p - beg_ff), 64'd0, 1'b0};
                  cnt_in = 2'd1; restart = 1'b1;
               end
            end
            M_NEG, M_ZERO, M_INT: begin
               if (mode_ff == M_NEG && b == "0") mode_in = M_ZERO;
               else if (dig && mode_ff != M_ZERO) begin
                  mode_in = M_INT;
                  if (!ovf_ff) begin
                     if (mag_ff > lim) ovf_in = 1'b1;
                     else mag_in = 63'(mag_ff * 63'd10) + 63'(d);
                  end
               end else if (mode_ff == M_NEG) begin
                  t0_in = '{K_ERROR, 32'(beg_ff), 32'(p - beg_ff), 64'd0, 1'b0};
                  cnt_in = 2'd1; restart = 1'b1;
               end else if (b == ".") begin
                  mode_in = M_DOT; frc_in = 1'b1;
               end else if (ech) begin
                  mode_in = M_EXP; frc_in = 1'b1;
               end else begin
                  t0_in = '{frc_ff ? K_FRAC : K_INT, 32'(beg_ff), 32'(p - beg_ff), v, 1'b0};
                  cnt_in = 2'd1; restart = 1'b1;
               end
            end
            M_DOT, M_EXP, M_EXPS: begin
               if (dig) mode_in = (mode_ff == M_DOT) ? M_FRAC : M_EXPD;
               else if (mode_ff == M_EXP && (b == "+" || b == "-")) mode_in = M_EXPS;
               else begin
                  t0_in = '{K_ERROR, 32'(beg_ff), 32'(p - beg_ff), 64'd0, 1'b0};
                  cnt_in = 2'd1; restart = 1'b1;
               end
            end
            M_FRAC, M_EXPD: begin
               if (dig) ;
               else if (mode_ff == M_FRAC && ech) mode_in = M_EXP;
               else begin
                  t0_in = '{K_FRAC, 32'(beg_ff), 32'(p - beg_ff), v, 1'b0};
                  cnt_in = 2'd1; restart = 1'b1;
               end
            end
            default: begin
               mode_in = M_IDLE; restart = 1'b1;
            end
         endcase

         if (restart) begin
            mode_in = M_IDLE;
            tk = '{K_ERROR, 32'(p), 32'd1, 64'd0, 1'b0};
            case (b)
               " ", "\t", "\r", "\n": tk.last = 1'b0;
               "{": tk.kind = K_LBRACE;
               "}": tk.kind = K_RBRACE;
               "[": tk.kind = K_LBRACK;
               "]": tk.kind = K_RBRACK;
               ":": tk.kind = K_COLON;
               ",": tk.kind = K_COMMA;
               default: tk.kind = K_ERROR;
            endcase
            case (b)
               " ", "\t", "\r", "\n": ;
               "\"": begin mode_in = M_STR; beg_in = p + 1'b1; end
               "t", "f", "n": begin
                  mode_in = M_LIT; lidx_in = 3'd1; beg_in = p;
                  lsel_in = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
               end
               "-", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
                  mode_in = (b == "-") ? M_NEG : (b == "0") ? M_ZERO : M_INT;
                  beg_in = p; neg_in = b == "-"; frc_in = 1'b0; ovf_in = 1'b0;
                  mag_in = (b == "-") ? 63'd0 : 63'(d);
               end
               default: begin
                  if (cnt_in == 2'd1) t1_in = tk; else t0_in = tk;
                  cnt_in = cnt_in + 2'd1;
               end
            endcase
         end
         if (cnt_in == 2'd2) t1_in.last = 1'b1;
         else if (cnt_in == 2'd1) t0_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         t0_ff <= t0_in;
         t1_ff <= t1_in;
         cnt_ff <= cnt_in;
      end
      if (reset) begin
         mode_ff <= M_IDLE; pos_ff <= '0; beg_ff <= '0; mag_ff <= '0;
         ovf_ff <= 1'b0; neg_ff <= 1'b0; frc_ff <= 1'b0;
         lidx_ff <= '0; lsel_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            mode_ff  <= mode_in;
            pos_ff <= pos_in; beg_ff <= beg_in; mag_ff <= mag_in;
            ovf_ff <= ovf_in; neg_ff <= neg_in; frc_ff <= frc_in;
            lidx_ff <= lidx_in; lsel_ff <= lsel_in;
            valid_ff <= cnt_in != 2'd0;
         end else if (out_free) valid_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/jbt_emit.sv =====
`default_nettype none
//------------------------------------------------------------------------------
// jbt_emit
// Token output stage: holds up to two tokens and hands them out one per pop.
//------------------------------------------------------------------------------
module jbt_emit (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   input  wire [1:0]          in_count,
   input  wire jbt_pkg::token_type in_tok0,
   input  wire jbt_pkg::token_type in_tok1,
   output logic               in_free,
   output logic               empty,
   input  wire                pop,
   output jbt_pkg::token_type tok
);
   import jbt_pkg::*;

   token_type  t0_ff, t1_ff;
   logic [1:0] cnt_ff;
   logic       done;

   assign empty   = cnt_ff == 2'd0;
   assign tok     = t0_ff;
   assign done    = pop && cnt_ff == 2'd1;
   assign in_free = empty || done;

   always_ff @(posedge clock) begin
      if (in_valid && in_free) begin
         t0_ff <= in_tok0;
         t1_ff <= in_tok1;
      end else if (pop && !empty) t0_ff <= t1_ff;
      if (reset) cnt_ff <= 2'd0;
      else if (in_valid && in_free) cnt_ff <= in_count;
      else if (pop && !empty) cnt_ff <= cnt_ff - 2'd1;
   end
endmodule
`default_nettype wire
